FILE: hw/rtl/tccw_pkg.sv
// Shared widths, screen geometry and action codes for the text console cursor writer.
package tccw_pkg;

   // Screen geometry.
   localparam int unsigned COLUMNS = 80;
   localparam int unsigned ROWS    = 25;

   // Field widths.
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned COL_W    = 7;
   localparam int unsigned ROW_W    = 5;
   localparam int unsigned IDX_W    = 11;

   // Packed word widths, rounded up to whole bytes.
   localparam int unsigned REQ_FIELDS_W = CHAR_W + COL_W + ROW_W;
   localparam int unsigned REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int unsigned RSP_FIELDS_W = 1 + IDX_W + CHAR_W + 1 + IDX_W;
   localparam int unsigned RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Action codes carried in the request tuser.
   localparam logic [ACTION_W-1:0] ACT_PUT_CHAR   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SET_CURSOR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR      = 2'd2;

   // Character that moves the cursor to the start of the next row.
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;

   // Last legal cursor coordinates.
   localparam logic [COL_W-1:0] LAST_COLUMN = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(ROWS - 1);

   // Number of cells on the screen.
   localparam logic [IDX_W-1:0] CELL_COUNT = IDX_W'(COLUMNS * ROWS);

endpackage

FILE: hw/rtl/text_console_cursor_writer_top.sv
// Text console cursor writer: turns console actions into screen-cell writes and cursor updates.
//
// The block takes one request word per action on the req_ channel and returns exactly one
// response word on the rsp_ channel for each. A request's tuser carries the action (put
// character, set cursor, clear screen); its tdata carries the character and the new cursor
// coordinates. A response tells the screen memory whether to write a character byte into a
// cell (keeping that cell's attribute), whether to clear the whole screen after that write,
// and the new linear cursor position (row times 80 plus column).
//
// A request word is captured in an input register; whenever the response register is empty
// or being emptied, the cursor logic takes the word from there, updates the column and row
// registers and loads the response register. The cursor update is one small add and compare,
// so one word is taken every cycle for as long as the receiver keeps up.
// When the receiver stalls, the response register holds its word and the input register
// keeps one more; req_tready falls only once both are full, and rises again in the same
// cycle that the response is taken.
//
// Synchronous reset empties both registers and puts the cursor at column 0, row 0.
module text_console_cursor_writer_top (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: char_code [7:0], new_column [14:8], new_row [19:15], zero fill [23:20].
   input  logic [tccw_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: action [1:0].
   input  logic [tccw_pkg::ACTION_W-1:0]     req_tuser,
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: cell_write [0], cell_index [11:1], cell_char [19:12], clear_request [20],
   //        cursor_position [31:21].
   output logic [tccw_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int unsigned COL_W  = tccw_pkg::COL_W;
   localparam int unsigned ROW_W  = tccw_pkg::ROW_W;
   localparam int unsigned IDX_W  = tccw_pkg::IDX_W;
   localparam int unsigned CHAR_W = tccw_pkg::CHAR_W;

   // Linear cell index of a cursor position.
   function automatic logic [IDX_W-1:0] linear_pos(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      logic [IDX_W-1:0] product;
      product = IDX_W'(r) * IDX_W'(tccw_pkg::COLUMNS);
      return product + IDX_W'(c);
   endfunction

   // Input register.
   logic                           in_valid_ff,  in_valid_in;
   logic [tccw_pkg::ACTION_W-1:0]  in_action_ff;
   logic [CHAR_W-1:0]              in_char_ff;
   logic [COL_W-1:0]               in_col_ff;
   logic [ROW_W-1:0]               in_row_ff;

   // Cursor state.
   logic [COL_W-1:0]               column_ff, column_in;
   logic [ROW_W-1:0]               row_ff,    row_in;

   // Response register.
   logic                           out_valid_ff, out_valid_in;
   logic                           out_write_ff, out_write_in;
   logic [IDX_W-1:0]               out_index_ff, out_index_in;
   logic [CHAR_W-1:0]              out_char_ff,  out_char_in;
   logic                           out_clear_ff, out_clear_in;
   logic [IDX_W-1:0]               out_cursor_ff, out_cursor_in;

   logic                           req_fire;
   logic                           advance;
   logic [COL_W:0]                 col_step;
   logic [ROW_W:0]                 row_step;

   // The input word moves on whenever the response register is empty or being emptied.
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   // Cursor logic for the word in the input register.
   always_comb begin
      column_in    = column_ff;
      row_in       = row_ff;
      out_write_in = 1'b0;
      out_index_in = '0;
      out_char_in  = '0;
      out_clear_in = 1'b0;
      col_step     = {1'b0, column_ff};
      row_step     = {1'b0, row_ff};
      case (in_action_ff)
         tccw_pkg::ACT_PUT_CHAR: begin
            if (in_char_ff == tccw_pkg::NEWLINE_CODE) begin
               col_step = '0;
               row_step = {1'b0, row_ff} + (ROW_W+1)'(1);
            end else begin
               out_write_in = 1'b1;
               out_index_in = linear_pos(row_ff, column_ff);
               out_char_in  = in_char_ff;
               col_step     = {1'b0, column_ff} + (COL_W+1)'(1);
            end
            // Wrap to the start of the next row at the right edge.
            if (col_step >= (COL_W+1)'(tccw_pkg::COLUMNS)) begin
               col_step = '0;
               row_step = row_step + (ROW_W+1)'(1);
            end
            // Running off the bottom clears the screen and homes the cursor.
            if (row_step >= (ROW_W+1)'(tccw_pkg::ROWS)) begin
               out_clear_in = 1'b1;
               col_step     = '0;
               row_step     = '0;
            end
            column_in = col_step[COL_W-1:0];
            row_in    = row_step[ROW_W-1:0];
         end
         tccw_pkg::ACT_SET_CURSOR: begin
            // Coordinates beyond the screen saturate at its last column and row.
            column_in = (in_col_ff > tccw_pkg::LAST_COLUMN) ? tccw_pkg::LAST_COLUMN : in_col_ff;
            row_in    = (in_row_ff > tccw_pkg::LAST_ROW)    ? tccw_pkg::LAST_ROW    : in_row_ff;
         end
         tccw_pkg::ACT_CLEAR: begin
            out_clear_in = 1'b1;
            column_in    = '0;
            row_in       = '0;
         end
         default: begin
            // Unused action code: nothing changes, the cursor is reported as it is.
         end
      endcase
      out_cursor_in = linear_pos(row_in, column_in);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         column_ff    <= '0;
         row_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            column_ff <= column_in;
            row_ff    <= row_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_action_ff <= req_tuser;
         in_char_ff   <= req_tdata[7:0];
         in_col_ff    <= req_tdata[14:8];
         in_row_ff    <= req_tdata[19:15];
      end
      if (advance) begin
         out_write_ff  <= out_write_in;
         out_index_ff  <= out_index_in;
         out_char_ff   <= out_char_in;
         out_clear_ff  <= out_clear_in;
         out_cursor_ff <= out_cursor_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = tccw_pkg::RSP_DATA_W'({out_cursor_ff, out_clear_ff, out_char_ff,
                                               out_index_ff, out_write_ff});

`ifndef SYNTHESIS
   // The cursor never leaves the screen.
   assert property (@(posedge clock) disable iff (reset)
      (column_ff <= tccw_pkg::LAST_COLUMN) && (row_ff <= tccw_pkg::LAST_ROW))
      else $error("cursor state left the screen");

   // A reported cursor position is always a cell of the screen.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_cursor_ff < tccw_pkg::CELL_COUNT))
      else $error("cursor position beyond the last cell");

   // A clear always homes the cursor.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_clear_ff) |-> (out_cursor_ff == '0))
      else $error("clear request without the cursor at home");

   // The cursor only moves when a word passes from the input to the response register.
   assert property (@(posedge clock) disable iff (reset)
      !$past(advance) |-> ($stable(column_ff) && $stable(row_ff)))
      else $error("cursor moved without a word being processed");
`endif

endmodule

FILE: tb/sv/text_console_cursor_writer_top_test.sv
// Self-checking testbench for the text console cursor writer top level.
module text_console_cursor_writer_top_test;

   // The one action code that the block takes and ignores.
   localparam logic [tccw_pkg::ACTION_W-1:0] ACT_RESERVED = 2'd3;

   // The receiver's long hold-off, in cycles.
   localparam int HOLD_CYCLES = 48;

   // The run fails once this many cycles pass with no word moved on either channel.
   localparam int QUIET_LIMIT = 2000;

   // Number of random words per phase, ignored actions not included.
   localparam int PHASE_WORDS = 548;

   // One response word as the block packs it.
   // The first member lands in the highest bits, so the order here is the reverse of the
   // port comment and a plain cast unpacks rsp_tdata.
   typedef struct packed {
      logic [tccw_pkg::IDX_W-1:0]  cursor_position;
      logic                        clear_request;
      logic [tccw_pkg::CHAR_W-1:0] cell_char;
      logic [tccw_pkg::IDX_W-1:0]  cell_index;
      logic                        cell_write;
   } screen_update_type;

   // Tracks the cursor on its own, predicts the screen update for every request word,
   // and compares each response word with the oldest prediction.
   class screen_update_scoreboard_type;
      int unsigned       cursor_column;
      int unsigned       cursor_row;
      screen_update_type expected_updates[$];
      int                mismatches;

      function new();
         cursor_column = 0;
         cursor_row    = 0;
         mismatches    = 0;
      endfunction

      function logic [tccw_pkg::IDX_W-1:0] linear_position();
         return (tccw_pkg::IDX_W)'(cursor_row * tccw_pkg::COLUMNS + cursor_column);
      endfunction

      function int pending();
         return expected_updates.size();
      endfunction

      task report(input string what);
         $display("tb: mismatch: %s", what);
         mismatches++;
      endtask

      // Applies one accepted request word to the cursor and queues the update it causes.
      function void note_request(input logic [tccw_pkg::ACTION_W-1:0] action,
                                 input logic [tccw_pkg::REQ_DATA_W-1:0] data);
         screen_update_type           upd;
         logic [tccw_pkg::CHAR_W-1:0] char_code;
         logic [tccw_pkg::COL_W-1:0]  new_column;
         logic [tccw_pkg::ROW_W-1:0]  new_row;
         char_code  = data[tccw_pkg::CHAR_W-1:0];
         new_column = data[tccw_pkg::CHAR_W +: tccw_pkg::COL_W];
         new_row    = data[tccw_pkg::CHAR_W+tccw_pkg::COL_W +: tccw_pkg::ROW_W];
         upd        = '0;
         case (action)
            tccw_pkg::ACT_PUT_CHAR: begin
               if (char_code == tccw_pkg::NEWLINE_CODE) begin
                  cursor_column = 0;
                  cursor_row++;
               end else begin
                  upd.cell_write = 1'b1;
                  upd.cell_index = linear_position();
                  upd.cell_char  = char_code;
                  cursor_column++;
               end
               if (cursor_column >= tccw_pkg::COLUMNS) begin
                  cursor_column = 0;
                  cursor_row++;
               end
               // Running off the bottom clears the screen, erasing this very write.
               if (cursor_row >= tccw_pkg::ROWS) begin
                  upd.clear_request = 1'b1;
                  cursor_column     = 0;
                  cursor_row        = 0;
               end
            end
            tccw_pkg::ACT_SET_CURSOR: begin
               // Coordinates beyond the screen saturate to the last column and row.
               cursor_column = (new_column >= tccw_pkg::COLUMNS) ?
                               tccw_pkg::COLUMNS - 1 : new_column;
               cursor_row    = (new_row >= tccw_pkg::ROWS) ? tccw_pkg::ROWS - 1 : new_row;
            end
            tccw_pkg::ACT_CLEAR: begin
               upd.clear_request = 1'b1;
               cursor_column     = 0;
               cursor_row        = 0;
            end
            default: begin
               // The reserved action changes nothing but still reports the cursor.
            end
         endcase
         upd.cursor_position = linear_position();
         expected_updates.push_back(upd);
      endfunction

      task check_response(input logic [tccw_pkg::RSP_DATA_W-1:0] data);
         screen_update_type got;
         screen_update_type want;
         got = screen_update_type'(data);
         if (expected_updates.size() == 0) begin
            report($sformatf("response word %h with no request outstanding", data));
         end else begin
            want = expected_updates.pop_front();
            if (got.cell_write !== want.cell_write)
               report($sformatf("cell_write %b, predicted %b", got.cell_write, want.cell_write));
            if (got.cell_index !== want.cell_index)
               report($sformatf("cell_index %0d, predicted %0d",
                                got.cell_index, want.cell_index));
            if (got.cell_char !== want.cell_char)
               report($sformatf("cell_char %h, predicted %h", got.cell_char, want.cell_char));
            if (got.clear_request !== want.clear_request)
               report($sformatf("clear_request %b, predicted %b",
                                got.clear_request, want.clear_request));
            if (got.cursor_position !== want.cursor_position)
               report($sformatf("cursor_position %0d, predicted %0d",
                                got.cursor_position, want.cursor_position));
         end
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [tccw_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [tccw_pkg::ACTION_W-1:0]   req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [tccw_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // Idle rates in percent, changed by the stimulus process from phase to phase.
   int tx_idle_pct;
   int rx_stall_pct;

   // The stimulus process asks for a long hold-off by bumping the request count; the
   // receiver serves it and counts the cycles itself.
   int hold_requests;
   int hold_served;

   screen_update_scoreboard_type scoreboard = new();

   text_console_cursor_writer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Both monitors sample at the rising edge, before any of this edge's updates land, so
   // they see exactly the handshake that the block sees.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         scoreboard.note_request(req_tuser, req_tdata);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         scoreboard.check_response(rsp_tdata);
   end

   // Watchdog: a long stretch with no word accepted on either side means the block hung.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
            quiet = 0;
         else
            quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   // Receiver: stalls at the current rate, or holds off for a long stretch when asked.
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_served != hold_requests) begin
            hold_served++;
            repeat (HOLD_CYCLES) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            @(posedge clock);
         end
      end
   end

   // Request word layout: char_code, new_column, new_row from the lowest bit up, then zeros.
   function automatic logic [tccw_pkg::REQ_DATA_W-1:0] pack_request(
      input logic [tccw_pkg::CHAR_W-1:0] char_code,
      input logic [tccw_pkg::COL_W-1:0]  new_column,
      input logic [tccw_pkg::ROW_W-1:0]  new_row);
      return (tccw_pkg::REQ_DATA_W)'({new_row, new_column, char_code});
   endfunction

   // Offers one request word, idling first at the current rate, and returns once it is taken.
   // The valid is left high so that back-to-back words see no gap.
   task automatic send_word(input logic [tccw_pkg::ACTION_W-1:0]   action,
                            input logic [tccw_pkg::REQ_DATA_W-1:0] data);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // The sender stops until every predicted update has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (scoreboard.pending() != 0) @(posedge clock);
   endtask

   initial begin
      logic [tccw_pkg::ACTION_W-1:0] action;
      logic [tccw_pkg::CHAR_W-1:0]   char_code;
      logic [tccw_pkg::COL_W-1:0]    new_column;
      logic [tccw_pkg::ROW_W-1:0]    new_row;
      int                            roll;
      int                            sent;

      hold_requests = 0;
      hold_served   = 0;
      tx_idle_pct   = 10;
      rx_stall_pct  = 62;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= tccw_pkg::ACT_PUT_CHAR;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words: the byte extremes, newline, every action, saturation of the cursor
      // coordinates, wrapping at the right edge, and running off the bottom row both by a
      // character and by a newline.
      send_word(tccw_pkg::ACT_PUT_CHAR,   pack_request(8'h00, '0, '0));
      send_word(tccw_pkg::ACT_PUT_CHAR,   pack_request(8'hFF, '0, '0));
      send_word(tccw_pkg::ACT_PUT_CHAR,   pack_request(tccw_pkg::NEWLINE_CODE, '0, '0));
      send_word(tccw_pkg::ACT_SET_CURSOR, pack_request(8'hFF, 7'd0, 5'd0));
      send_word(tccw_pkg::ACT_SET_CURSOR,
                pack_request(8'h00, tccw_pkg::LAST_COLUMN, tccw_pkg::LAST_ROW));
      send_word(tccw_pkg::ACT_PUT_CHAR,   pack_request(8'h41, '0, '0));
      send_word(tccw_pkg::ACT_SET_CURSOR, pack_request(8'h00, '1, '1));
      send_word(tccw_pkg::ACT_PUT_CHAR,   pack_request(tccw_pkg::NEWLINE_CODE, '1, '1));
      send_word(tccw_pkg::ACT_SET_CURSOR,
                pack_request(8'h5A, 7'(tccw_pkg::COLUMNS), 5'(tccw_pkg::ROWS)));
      send_word(ACT_RESERVED,             pack_request('1, '1, '1));
      send_word(tccw_pkg::ACT_CLEAR,      pack_request('1, '1, '1));
      send_word(tccw_pkg::ACT_SET_CURSOR, pack_request(8'h00, tccw_pkg::LAST_COLUMN, 5'd10));
      send_word(tccw_pkg::ACT_PUT_CHAR,   pack_request(8'h55, '0, '0));
      send_word(tccw_pkg::ACT_PUT_CHAR,   pack_request(tccw_pkg::NEWLINE_CODE, '1, '1));
      send_word(ACT_RESERVED,             pack_request('0, '0, '0));
      send_word(tccw_pkg::ACT_PUT_CHAR,   pack_request(8'hAA, 7'h55, 5'h0A));
      send_word(tccw_pkg::ACT_SET_CURSOR, pack_request(8'h20, 7'd0, tccw_pkg::LAST_ROW));
      send_word(tccw_pkg::ACT_PUT_CHAR,   pack_request(8'h20, 7'h2A, 5'h15));
      drain();

      // Random words in three phases: a stalling receiver, then an idling sender, then
      // neither. The last phase opens with a long receiver hold-off while the sender keeps
      // offering, so the block fills up and drops req_tready.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct  = 10;
               rx_stall_pct = 62;
            end
            1: begin
               tx_idle_pct  = 62;
               rx_stall_pct = 10;
            end
            default: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 0;
               hold_requests++;
            end
         endcase
         sent = 0;
         while (sent < PHASE_WORDS) begin
            roll       = $urandom_range(0, 99);
            char_code  = (tccw_pkg::CHAR_W)'($urandom_range(0, 255));
            new_column = (tccw_pkg::COL_W)'($urandom_range(0, 127));
            new_row    = (tccw_pkg::ROW_W)'($urandom_range(0, 31));
            // Mostly text with newlines, so the cursor walks down and off the bottom; now
            // and then a jump, a clear or the reserved action.
            if (roll < 70) begin
               action = tccw_pkg::ACT_PUT_CHAR;
               if ($urandom_range(0, 99) < 15)
                  char_code = tccw_pkg::NEWLINE_CODE;
            end else if (roll < 87) begin
               action = tccw_pkg::ACT_SET_CURSOR;
               if ($urandom_range(0, 3) != 0) begin
                  new_column = (tccw_pkg::COL_W)'($urandom_range(0, tccw_pkg::COLUMNS - 1));
                  new_row    = (tccw_pkg::ROW_W)'($urandom_range(0, tccw_pkg::ROWS - 1));
               end
            end else if (roll < 94) begin
               action = tccw_pkg::ACT_CLEAR;
            end else begin
               action = ACT_RESERVED;
            end
            send_word(action, pack_request(char_code, new_column, new_row));
            if (action != ACT_RESERVED)
               sent++;
         end
         drain();
      end

      // Let the clock run on so that a stray extra response would still be caught.
      repeat (8) @(posedge clock);
      if (scoreboard.mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/tccw_pkg.sv
hw/rtl/text_console_cursor_writer_top.sv
tb/sv/text_console_cursor_writer_top_test.sv
